// ===== design/pwc_pkg.sv =====
// package for the primitive widening converter
// type codes and the permission table; no dependencies
package pwc_pkg;

    typedef enum logic [3:0] {
        T_NONE   = 4'd0,
        T_SHORT  = 4'd1,
        T_INT    = 4'd2,
        T_LONG   = 4'd3,
        T_BYTE   = 4'd4,
        T_CHAR   = 4'd5,
        T_FLOAT  = 4'd6,
        T_DOUBLE = 4'd7,
        T_BOOL   = 4'd8
    } type_code_t;

    // bit (to - 1) set if that target is permitted for the source code
    function automatic logic [7:0] allowed_targets(input logic [3:0] from_code);
        logic [7:0] m;
        begin
            case (from_code)
                T_SHORT:  m = 8'h67;
                T_INT:    m = 8'h66;
                T_LONG:   m = 8'h64;
                T_BYTE:   m = 8'h6f;
                T_CHAR:   m = 8'h76;
                T_FLOAT:  m = 8'h60;
                T_DOUBLE: m = 8'h40;
                T_BOOL:   m = 8'h80;
                default:  m = 8'h00;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== design/primitive_widening_converter.sv =====
// primitive widening converter top level: input and result registers
// result valid once the request has passed the input register and then the result register (two register stages)
// one request per cycle when the output is taken every cycle; stalls hold both stages
// reset clears the valid flags only; payload registers are not reset
// depends on pwc_pkg and pwc_convert
module primitive_widening_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  from_type,
    input  logic [3:0]  to_type,
    input  logic [63:0] src_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] dst_value,
    output logic        ok
);
    import pwc_pkg::*;

    logic        a_valid_reg;
    logic [3:0]  from_reg;
    logic [3:0]  to_reg;
    logic [63:0] src_reg;
    logic        b_valid_reg;
    logic [63:0] dst_reg;
    logic        ok_reg;
    logic [63:0] dst_next;
    logic        ok_next;
    logic        b_load;
    logic        a_load;

    pwc_convert u_conv (
        .from_type (from_reg),
        .to_type   (to_reg),
        .src_value (src_reg),
        .dst_value (dst_next),
        .ok        (ok_next)
    );

    assign b_load = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || b_load;
    assign a_load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_load)
                b_valid_reg <= 1'b1;
            else if (out_ready)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            from_reg <= from_type;
            to_reg   <= to_type;
            src_reg  <= src_value;
        end
        if (b_load)
        begin
            dst_reg <= dst_next;
            ok_reg  <= ok_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign dst_value = dst_reg;
    assign ok = ok_reg;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(dst_value)))
        else $error("result changed under stall");
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_load) |=> a_valid_reg)
        else $error("input stage lost a request");
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg && !out_ready) |-> !in_ready)
        else $error("ready while both stages full");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (dst_value == 64'd0))
        else $error("forbidden pair gave nonzero result");
`endif

endmodule

// ===== design/pwc_convert.sv =====
// conversion datapath of the primitive widening converter
// combinational only; uses pwc_pkg
module pwc_convert (
    input  logic [3:0]  from_type,
    input  logic [3:0]  to_type,
    input  logic [63:0] src_value,
    output logic [63:0] dst_value,
    output logic        ok
);
    import pwc_pkg::*;

    logic [63:0] iv;
    logic        neg;
    logic [63:0] mag;
    logic [5:0]  p;
    logic [63:0] norm;
    logic [31:0] f_bits;
    logic [63:0] d_bits;
    logic [23:0] fm;
    logic [52:0] dm;
    logic        f_rnd;
    logic        d_rnd;
    logic [24:0] fm_r;
    logic [53:0] dm_r;
    logic [7:0]  fe;
    logic [10:0] de;
    logic [31:0] fs;
    logic [7:0]  sx;
    logic [22:0] sf;
    logic [4:0]  sp;
    logic [22:0] snorm;
    logic [63:0] s2d;
    logic [7:0]  allow;
    logic        permit;

    always_comb
    begin
        case (from_type)
            T_BYTE:  iv = {{56{src_value[7]}}, src_value[7:0]};
            T_SHORT: iv = {{48{src_value[15]}}, src_value[15:0]};
            T_CHAR:  iv = {48'd0, src_value[15:0]};
            T_INT:   iv = {{32{src_value[31]}}, src_value[31:0]};
            default: iv = src_value;
        endcase
    end

    always_comb
    begin
        neg = iv[63];
        mag = neg ? (64'd0 - iv) : iv;
        p = 6'd0;
        for (int i = 0; i < 64; i++)
        begin
            if (mag[i])
                p = 6'(i);
        end
        // leading one moved to bit 63
        norm = mag << (6'd63 - p);
        fm = norm[63:40];
        f_rnd = norm[39] & ((|norm[38:0]) | norm[40]);
        fm_r = {1'b0, fm} + {24'd0, f_rnd};
        fe = 8'(p) + 8'd127 + {7'd0, fm_r[24]};
        f_bits = (mag == 64'd0) ? 32'd0
               : {neg, fe, fm_r[24] ? fm_r[23:1] : fm_r[22:0]};
        dm = norm[63:11];
        d_rnd = norm[10] & ((|norm[9:0]) | norm[11]);
        dm_r = {1'b0, dm} + {53'd0, d_rnd};
        de = 11'(p) + 11'd1023 + {10'd0, dm_r[53]};
        d_bits = (mag == 64'd0) ? 64'd0
               : {neg, de, dm_r[53] ? dm_r[52:1] : dm_r[51:0]};
    end

    always_comb
    begin
        fs = src_value[31:0];
        sx = fs[30:23];
        sf = fs[22:0];
        sp = 5'd0;
        for (int i = 0; i < 23; i++)
        begin
            if (sf[i])
                sp = 5'(i);
        end
        snorm = sf << (5'd23 - sp);
        if (sx == 8'hff)
            s2d = {fs[31], 11'h7ff, sf, 29'd0};
        else if (sx == 8'd0)
            s2d = (sf == 23'd0) ? {fs[31], 63'd0}
                : {fs[31], 11'(sp) + 11'd874, snorm, 29'd0};
        else
            s2d = {fs[31], {3'd0, sx} + 11'd896, sf, 29'd0};
    end

    always_comb
    begin
        allow = allowed_targets(from_type);
        permit = (to_type >= 4'd1) && (to_type <= 4'd8)
               && allow[3'(to_type - 4'd1)];
        ok = permit;
        dst_value = 64'd0;
        if (permit)
        begin
            if (from_type == to_type)
                dst_value = (to_type == T_LONG || to_type == T_DOUBLE)
                          ? src_value : {32'd0, src_value[31:0]};
            else if (from_type == T_FLOAT)
                dst_value = s2d;
            else
            begin
                case (to_type)
                    T_SHORT, T_INT: dst_value = {32'd0, iv[31:0]};
                    T_LONG:         dst_value = iv;
                    T_FLOAT:        dst_value = {32'd0, f_bits};
                    default:        dst_value = d_bits;
                endcase
            end
        end
    end

endmodule
